@@ rtl/assert_macros.svh @@
// Assertion helpers for the oscillator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define WMO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("wmo assertion failed");

// Check a property on every clock edge, reset included.
`define WMO_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("wmo reset assertion failed");

`endif

@@ rtl/wmo_pkg.sv @@
// ----------------------------------------------------------------------------
// wmo_pkg
// Constants, types and the 2^x table of the wavetable morph oscillator.
// ----------------------------------------------------------------------------
package wmo_pkg;

  localparam int TABLE_BITS  = 8;
  localparam int BANK_BITS   = 3;
  localparam int WAVE_BITS   = 3;
  localparam int ADDR_BITS   = BANK_BITS + WAVE_BITS + TABLE_BITS;
  localparam int MEM_DEPTH   = 1 << ADDR_BITS;
  localparam int SAMPLE_BITS = 16;

  localparam logic [3:0]  MAX_BANKS      = 4'd8;
  localparam logic [3:0]  MAX_WAVES      = 4'd8;
  localparam logic [31:0] BASE_INC_RESET = 32'd23410276;

  // Register word indexes
  localparam logic [1:0] REG_BANK_COUNT = 2'd0;
  localparam logic [1:0] REG_WAVE_COUNT = 2'd1;
  localparam logic [1:0] REG_BASE_INC   = 2'd2;

  // Operands of the shared multiplier
  typedef struct packed {
    logic signed [32:0] a;
    logic signed [24:0] b;
  } mul_op_t;

  // 2^(k/16) in Q2.16
  function automatic logic [17:0] exp2_lut(input logic [4:0] k);
    logic [17:0] v;
    case (k)
      5'd0:    v = 18'd65536;
      5'd1:    v = 18'd68438;
      5'd2:    v = 18'd71468;
      5'd3:    v = 18'd74632;
      5'd4:    v = 18'd77936;
      5'd5:    v = 18'd81386;
      5'd6:    v = 18'd84990;
      5'd7:    v = 18'd88752;
      5'd8:    v = 18'd92682;
      5'd9:    v = 18'd96785;
      5'd10:   v = 18'd101070;
      5'd11:   v = 18'd105545;
      5'd12:   v = 18'd110218;
      5'd13:   v = 18'd115098;
      5'd14:   v = 18'd120194;
      5'd15:   v = 18'd125515;
      5'd16:   v = 18'd131072;
      default: v = 18'd131072;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/wmo_if.sv @@
// ----------------------------------------------------------------------------
// wmo_if
// Valid/ready channels carrying input words and sample words.
// ----------------------------------------------------------------------------
interface wmo_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [15:0] pitch;
  logic [16:0]        bank_position;
  logic [16:0]        wave_position;
  logic [2:0]         load_bank;
  logic [2:0]         load_wave;
  logic [7:0]         load_index;
  logic signed [15:0] load_value;

  modport source (output valid, action, pitch, bank_position, wave_position,
                  load_bank, load_wave, load_index, load_value, input ready);
  modport sink (input valid, action, pitch, bank_position, wave_position,
                load_bank, load_wave, load_index, load_value, output ready);
endinterface

interface wmo_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

@@ rtl/wmo_ram.sv @@
// ----------------------------------------------------------------------------
// wmo_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wmo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/wmo_mul.sv @@
// ----------------------------------------------------------------------------
// wmo_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module wmo_mul
  import wmo_pkg::*;
(
  input  logic               clk_i,
  input  mul_op_t            op_i,
  output logic signed [57:0] prod_o
);

  logic signed [57:0] prod_q;

  // Register the product every cycle
  always_ff @(posedge clk_i) begin
    prod_q <= op_i.a * op_i.b;
  end

  assign prod_o = prod_q;

endmodule

@@ rtl/wavetable_morph_oscillator.sv @@
// A produce word runs morph steps, then pitch steps, before its sample is
// offered; a silent one (zero bank or wave count) yields a zero sample and a
// load word is written on acceptance. Words are taken only in idle, as the
// steps use the single multiplier and the single RAM read port in turn.
// Reset: control, counts, phase and base increment reset; the wavetable
// memory is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
// wavetable_morph_oscillator
// Wavetable oscillator with bilinear wave/bank morph, run by a small
// sequencer around one multiplier and one table RAM.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wavetable_morph_oscillator
  import wmo_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  wmo_in_if.sink      in_i,
  wmo_out_if.source   out_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_BMUL, ST_WMUL, ST_WCAP, ST_RDA, ST_RDB, ST_IMUL, ST_IACC,
    ST_F0, ST_F0C, ST_F1, ST_F1C, ST_F2, ST_F2C,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_DONE
  } state_e;

  // Configuration registers
  logic [3:0]  bank_count_q, wave_count_q;
  logic [31:0] base_inc_q;

  state_e             state_q;
  logic signed [15:0] pitch_q;
  logic [16:0]        bpos_q, wpos_q;
  logic [3:0]         nb_q, nw_q;
  logic [2:0]         blo_q, bhi_q, wlo_q, whi_q;
  logic [15:0]        bfrac_q, wfrac_q;
  logic [1:0]         corner_q;
  logic [15:0]        a_q;
  logic signed [25:0] iv_q [4];
  logic signed [25:0] t0_q, t1_q;
  logic [14:0]        q_q;
  logic [4:0]         os_q;
  logic [10:0]        r_q;
  logic [3:0]         k_q;
  logic [17:0]        mant_q;
  logic [31:0]        phase_q;
  logic [15:0]        res_q;
  logic [15:0]        sample_q;
  logic               out_valid_q;

  mul_op_t            mul_op;
  logic signed [57:0] prod;
  logic [15:0]        rdata;
  logic [ADDR_BITS-1:0] raddr;
  logic               ram_we;

  // APB write and read
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_count_q <= '0;
      wave_count_q <= '0;
      base_inc_q   <= BASE_INC_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_BANK_COUNT: bank_count_q <= pwdata[3:0];
        REG_WAVE_COUNT: wave_count_q <= pwdata[3:0];
        REG_BASE_INC:   base_inc_q   <= pwdata;
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BANK_COUNT: prdata = {28'd0, bank_count_q};
      REG_WAVE_COUNT: prdata = {28'd0, wave_count_q};
      REG_BASE_INC:   prdata = base_inc_q;
      default:        prdata = '0;
    endcase
  end

  // Saturated counts and clamped positions seen at acceptance
  logic [3:0]  nb_sat, nw_sat;
  logic [16:0] bpos_sat, wpos_sat;
  assign nb_sat   = (bank_count_q > MAX_BANKS) ? MAX_BANKS : bank_count_q;
  assign nw_sat   = (wave_count_q > MAX_WAVES) ? MAX_WAVES : wave_count_q;
  assign bpos_sat = in_i.bank_position[16] ? 17'h10000 : in_i.bank_position;
  assign wpos_sat = in_i.wave_position[16] ? 17'h10000 : in_i.wave_position;

  assign in_i.ready = (state_q == ST_IDLE);
  assign ram_we     = in_i.valid && in_i.ready && in_i.action;

  // Table memory
  wmo_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MEM_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ({in_i.load_bank, in_i.load_wave, in_i.load_index}),
    .wdata_i (in_i.load_value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  wmo_mul u_mul (
    .clk_i  (clk_i),
    .op_i   (mul_op),
    .prod_o (prod)
  );

  // Corner and table index of the current read
  logic [2:0] cbank, cwave;
  logic [7:0] idx, nxt;
  assign cbank = corner_q[1] ? bhi_q : blo_q;
  assign cwave = corner_q[0] ? whi_q : wlo_q;
  assign idx   = phase_q[31:24];
  assign nxt   = idx + 8'd1;
  assign raddr = (state_q == ST_RDB) ? {cbank, cwave, nxt} : {cbank, cwave, idx};

  // Differences fed to the multiplier
  logic signed [16:0] sdiff;
  logic signed [26:0] fd0, fd1, fd2;
  logic [17:0]        lut_lo, lut_hi;
  logic [12:0]        lut_diff;
  logic [10:0]        k96;
  logic [6:0]         m;
  assign sdiff    = $signed({rdata[15], rdata}) - $signed({a_q[15], a_q});
  assign fd0      = {iv_q[1][25], iv_q[1]} - {iv_q[0][25], iv_q[0]};
  assign fd1      = {iv_q[3][25], iv_q[3]} - {iv_q[2][25], iv_q[2]};
  assign fd2      = {t1_q[25], t1_q} - {t0_q[25], t0_q};
  assign lut_lo   = exp2_lut({1'b0, k_q});
  assign lut_hi   = exp2_lut({1'b0, k_q} + 5'd1);
  assign lut_diff = 13'(lut_hi - lut_lo);
  assign k96      = {1'b0, k_q, 6'd0} + {2'b0, k_q, 5'd0};
  assign m        = 7'(r_q - k96);

  // Select multiplier operands per step
  always_comb begin
    mul_op.a = '0;
    mul_op.b = '0;
    case (state_q)
      ST_BMUL: begin
        mul_op.a = $signed({16'd0, bpos_q});
        mul_op.b = $signed({21'd0, nb_q - 4'd1});
      end
      ST_WMUL: begin
        mul_op.a = $signed({16'd0, wpos_q});
        mul_op.b = $signed({21'd0, nw_q - 4'd1});
      end
      ST_IMUL: begin
        mul_op.a = {{16{sdiff[16]}}, sdiff};
        mul_op.b = $signed({1'b0, phase_q[23:0]});
      end
      ST_F0: begin
        mul_op.a = {{6{fd0[26]}}, fd0};
        mul_op.b = $signed({9'd0, wfrac_q});
      end
      ST_F1: begin
        mul_op.a = {{6{fd1[26]}}, fd1};
        mul_op.b = $signed({9'd0, wfrac_q});
      end
      ST_F2: begin
        mul_op.a = {{6{fd2[26]}}, fd2};
        mul_op.b = $signed({9'd0, bfrac_q});
      end
      ST_P3: begin
        mul_op.a = $signed({20'd0, lut_diff});
        mul_op.b = $signed({18'd0, m});
      end
      ST_P4: begin
        mul_op.a = $signed({18'd0, prod[19:5]});
        mul_op.b = 25'sd43691;
      end
      ST_P6: begin
        mul_op.a = $signed({1'b0, base_inc_q});
        mul_op.b = $signed({7'd0, mant_q});
      end
      default: ;
    endcase
  end

  // Region split of a morph product
  logic [2:0] plo;
  logic [2:0] bhi_d, whi_d;
  assign plo   = prod[18:16];
  assign bhi_d = (({1'b0, plo} + 4'd1) >= nb_q) ? plo : plo + 3'd1;
  assign whi_d = (({1'b0, plo} + 4'd1) >= nw_q) ? plo : plo + 3'd1;

  // Interpolation, crossfade and rounding terms
  logic signed [25:0] iv_d, fade_d;
  logic signed [26:0] rnd;
  logic signed [18:0] srnd;
  logic [15:0]        sat_d;
  assign iv_d   = {{2{a_q[15]}}, a_q, 8'd0} + prod[41:16];
  assign fade_d = t0_q + prod[41:16];
  assign rnd    = {fade_d[25], fade_d} + 27'sd128;
  assign srnd   = rnd[26:8];
  assign sat_d  = (srnd > 19'sd32767) ? 16'h7FFF :
                  (srnd < -19'sd32768) ? 16'h8000 : srnd[15:0];

  // Pitch split into octave, segment and remainder
  logic signed [16:0] pclamp;
  logic [13:0]        os_tmp, k_tmp;
  logic [10:0]        r_d;
  logic [49:0]        inc_full;
  logic [4:0]         shamt;
  assign pclamp   = (pitch_q > 16'sd15360) ? 17'sd15360 :
                    (pitch_q < -16'sd15360) ? -17'sd15360 : {pitch_q[15], pitch_q};
  assign os_tmp   = {8'd0, q_q[14:9]} * 14'd171;
  assign r_d      = 11'(q_q - ({os_q, 10'd0} + {1'b0, os_q, 9'd0}));
  assign k_tmp    = {8'd0, r_d[10:5]} * 14'd171;
  assign shamt    = 5'd26 - os_q;
  assign inc_full = prod[49:0] >> shamt;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
      corner_q    <= '0;
    end else begin
      // Raise valid on a finished word, drop it once taken
      if (state_q == ST_DONE && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.valid && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_i.valid && !in_i.action) begin
            pitch_q <= in_i.pitch;
            bpos_q  <= bpos_sat;
            wpos_q  <= wpos_sat;
            nb_q    <= nb_sat;
            nw_q    <= nw_sat;
            if (nb_sat == 4'd0 || nw_sat == 4'd0) begin
              res_q   <= '0;
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_BMUL;
            end
          end
        end
        ST_BMUL: state_q <= ST_WMUL;
        ST_WMUL: begin
          blo_q   <= plo;
          bhi_q   <= bhi_d;
          bfrac_q <= prod[15:0];
          state_q <= ST_WCAP;
        end
        ST_WCAP: begin
          wlo_q    <= plo;
          whi_q    <= whi_d;
          wfrac_q  <= prod[15:0];
          corner_q <= '0;
          state_q  <= ST_RDA;
        end
        ST_RDA: state_q <= ST_RDB;
        ST_RDB: begin
          a_q     <= rdata;
          state_q <= ST_IMUL;
        end
        ST_IMUL: state_q <= ST_IACC;
        ST_IACC: begin
          iv_q[corner_q] <= iv_d;
          corner_q       <= corner_q + 2'd1;
          state_q        <= (corner_q == 2'd3) ? ST_F0 : ST_RDA;
        end
        ST_F0:  state_q <= ST_F0C;
        ST_F0C: begin
          t0_q    <= iv_q[0] + prod[41:16];
          state_q <= ST_F1;
        end
        ST_F1:  state_q <= ST_F1C;
        ST_F1C: begin
          t1_q    <= iv_q[2] + prod[41:16];
          state_q <= ST_F2;
        end
        ST_F2:  state_q <= ST_F2C;
        ST_F2C: begin
          res_q   <= sat_d;
          state_q <= ST_P0;
        end
        ST_P0: begin
          q_q     <= 15'(pclamp + 17'sd15360);
          state_q <= ST_P1;
        end
        ST_P1: begin
          os_q    <= os_tmp[13:9];
          state_q <= ST_P2;
        end
        ST_P2: begin
          r_q     <= r_d;
          k_q     <= k_tmp[12:9];
          state_q <= ST_P3;
        end
        ST_P3: state_q <= ST_P4;
        ST_P4: state_q <= ST_P5;
        ST_P5: begin
          mant_q  <= lut_lo + {5'd0, prod[29:17]};
          state_q <= ST_P6;
        end
        ST_P6: state_q <= ST_P7;
        ST_P7: begin
          phase_q <= phase_q + inc_full[31:0];
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            sample_q <= res_q;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.sample = sample_q;

  // Checks
  `WMO_ASSERT(a_valid_from_done, $rose(out_valid_q) |-> $past(state_q == ST_DONE))
  `WMO_ASSERT(a_phase_only_step, (state_q != ST_P7) |=> $stable(phase_q))
  `WMO_ASSERT(a_load_idle, ram_we |-> (state_q == ST_IDLE))
  `WMO_ASSERT_RST(a_reset_no_out, !rst_ni |=> !out_valid_q)

endmodule
